@@ design/midpoint_circle_rasterizer_macros.svh @@
// Assertion macros for the midpoint circle rasterizer checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_MACROS_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_MACROS_SVH

// Clocked assertion, ignored while reset is high.
`define MCR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define MCR_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/mcr_pkg.sv @@
// Shared constants and types for the midpoint circle rasterizer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package mcr_pkg;

   localparam int COORD_BITS_DEF = 16;   // default coordinate width
   localparam int CENTER_BITS    = 16;   // width of the center fields
   localparam int RADIUS_BITS    = 15;
   localparam int X_BITS         = 16;   // loop coordinates x and y
   localparam int D_BITS         = X_BITS + 2;  // decision term
   localparam int IDX_BITS       = 3;    // result index within one iteration

   localparam logic MODE_START   = 1'b0;
   localparam logic MODE_ADVANCE = 1'b1;

   localparam logic [IDX_BITS-1:0] LAST_IDX_FILL    = 3'd3;
   localparam logic [IDX_BITS-1:0] LAST_IDX_OUTLINE = 3'd7;

   // Control from the sequencer to the loop state.
   typedef struct packed {
      logic load;   // start a new circle
      logic step;   // retire one loop iteration
   } mcr_ctl_type;

endpackage
`default_nettype wire

@@ design/mcr_core.sv @@
// Loop state of the midpoint circle: center, x, y, decision term, mode, active.
// Depends on mcr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcr_core #(
   parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF,
   parameter int OUT_BITS   = COORD_BITS + 1
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire  mcr_pkg::mcr_ctl_type              ctl,
   input  wire  [mcr_pkg::CENTER_BITS-1:0]         load_cx,
   input  wire  [mcr_pkg::CENTER_BITS-1:0]         load_cy,
   input  wire  [mcr_pkg::RADIUS_BITS-1:0]         load_radius,
   input  wire                                     load_fill,
   output logic [mcr_pkg::X_BITS-1:0]              cur_x,
   output logic [mcr_pkg::X_BITS-1:0]              cur_y,
   output logic [OUT_BITS-1:0]                     origin_x,
   output logic [OUT_BITS-1:0]                     origin_y,
   output logic                                    fill_mode,
   output logic                                    run_ok,
   output logic                                    done_iter
);

   localparam int XB = mcr_pkg::X_BITS;
   localparam int DB = mcr_pkg::D_BITS;
   localparam int WB = COORD_BITS + mcr_pkg::CENTER_BITS;

   logic [XB-1:0]         x_ff, x_in, y_ff, y_in;
   logic [DB-1:0]         dec_ff, dec_in;
   logic [OUT_BITS-1:0]   ox_ff, ox_in, oy_ff, oy_in;
   logic                  fill_ff, fill_in, active_ff, active_in;

   logic [WB-1:0]         cx_wide, cy_wide;
   logic [COORD_BITS-1:0] cx_low, cy_low;
   logic                  dec_pos;
   logic [XB:0]           nx, ny, diff;
   logic [DB-1:0]         nd;

   // Low COORD_BITS of the center, sign-extended by one bit
   assign cx_wide = {{COORD_BITS{1'b0}}, load_cx};
   assign cy_wide = {{COORD_BITS{1'b0}}, load_cy};
   assign cx_low  = cx_wide[COORD_BITS-1:0];
   assign cy_low  = cy_wide[COORD_BITS-1:0];

   assign dec_pos   = $signed(dec_ff) > $signed(DB'(0));
   assign ny        = {1'b0, y_ff} + (XB+1)'(1);
   assign nx        = {1'b0, x_ff} - (dec_pos ? (XB+1)'(1) : (XB+1)'(0));
   assign diff      = ny - nx;
   assign nd        = dec_ff + (dec_pos ? {diff, 1'b0} : {ny, 1'b0}) + DB'(1);
   assign done_iter = $signed(nx) < $signed(ny);

   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      dec_in    = dec_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      fill_in   = fill_ff;
      active_in = active_ff;
      if (ctl.load) begin
         x_in      = {1'b0, load_radius};
         y_in      = '0;
         dec_in    = DB'(1) - DB'(load_radius);
         ox_in     = {cx_low[COORD_BITS-1], cx_low};
         oy_in     = {cy_low[COORD_BITS-1], cy_low};
         fill_in   = load_fill;
         active_in = 1'b1;
      end else if (ctl.step) begin
         x_in      = nx[XB-1:0];
         y_in      = ny[XB-1:0];
         dec_in    = nd;
         active_in = !done_iter;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff      <= '0;
         y_ff      <= '0;
         dec_ff    <= '0;
         ox_ff     <= '0;
         oy_ff     <= '0;
         fill_ff   <= 1'b0;
         active_ff <= 1'b0;
      end else begin
         x_ff      <= x_in;
         y_ff      <= y_in;
         dec_ff    <= dec_in;
         ox_ff     <= ox_in;
         oy_ff     <= oy_in;
         fill_ff   <= fill_in;
         active_ff <= active_in;
      end
   end

   assign cur_x     = x_ff;
   assign cur_y     = y_ff;
   assign origin_x  = ox_ff;
   assign origin_y  = oy_ff;
   assign fill_mode = fill_ff;
   assign run_ok    = active_ff && !(x_ff < y_ff);

endmodule
`default_nettype wire

@@ design/mcr_emit.sv @@
// Point and span generator: one of the eight symmetric results per index.
// Depends on mcr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcr_emit #(
   parameter int OUT_BITS = mcr_pkg::COORD_BITS_DEF + 1
) (
   input  wire  [mcr_pkg::X_BITS-1:0]   cur_x,
   input  wire  [mcr_pkg::X_BITS-1:0]   cur_y,
   input  wire  [OUT_BITS-1:0]          origin_x,
   input  wire  [OUT_BITS-1:0]          origin_y,
   input  wire                          fill_mode,
   input  wire  [mcr_pkg::IDX_BITS-1:0] idx,
   output logic [OUT_BITS-1:0]          px,
   output logic [OUT_BITS-1:0]          py_a,
   output logic [OUT_BITS-1:0]          py_b,
   output logic                         last
);

   localparam int EB = OUT_BITS + mcr_pkg::X_BITS;

   logic [EB-1:0]       xw, yw;
   logic [OUT_BITS-1:0] xo, yo, col_off, row_off, col_v, row_v;

   // Offsets are taken modulo 2^OUT_BITS, same as the final sums
   assign xw = {{OUT_BITS{1'b0}}, cur_x};
   assign yw = {{OUT_BITS{1'b0}}, cur_y};
   assign xo = xw[OUT_BITS-1:0];
   assign yo = yw[OUT_BITS-1:0];

   // idx[0] swaps x/y, idx[2]^idx[1] negates the column, idx[2] the row
   assign col_off = idx[0] ? yo : xo;
   assign row_off = idx[0] ? xo : yo;
   assign col_v   = (idx[1] ^ idx[2]) ? -col_off : col_off;
   assign row_v   = idx[2] ? -row_off : row_off;

   assign px   = origin_x + col_v;
   assign py_a = origin_y + row_v;
   assign py_b = fill_mode ? (origin_y - row_v) : (origin_y + row_v);
   assign last = fill_mode ? (idx == mcr_pkg::LAST_IDX_FILL)
                           : (idx == mcr_pkg::LAST_IDX_OUTLINE);

endmodule
`default_nettype wire

@@ design/midpoint_circle_rasterizer.sv @@
// Midpoint circle rasterizer, top level. A start transfer is held in the input register
// and loads the loop state from there; the results of an advance pass from the input
// register through the result register. Throughput: one start per cycle; a live advance
// produces one result per cycle unless rsp_ready stalls the result register, eight results (outline) or four (fill).
// Reset (synchronous, active high) makes the block idle and empties both registers.
`timescale 1ns / 1ps
`default_nettype none
module midpoint_circle_rasterizer #(
   parameter int  COORD_BITS = mcr_pkg::COORD_BITS_DEF,
   localparam int OUT_BITS   = COORD_BITS + 1
) (
   input  wire                                clock,
   input  wire                                reset,
   // request channel
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire                                req_mode,
   input  wire  signed [mcr_pkg::CENTER_BITS-1:0] req_center_x,
   input  wire  signed [mcr_pkg::CENTER_BITS-1:0] req_center_y,
   input  wire  [mcr_pkg::RADIUS_BITS-1:0]    req_radius,
   input  wire                                req_fill,
   // response channel
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic signed [OUT_BITS-1:0]         rsp_px,
   output logic signed [OUT_BITS-1:0]         rsp_py_a,
   output logic signed [OUT_BITS-1:0]         rsp_py_b,
   output logic                               rsp_last,
   output logic                               rsp_done_res
);

   localparam int XB = mcr_pkg::X_BITS;
   localparam int IB = mcr_pkg::IDX_BITS;

   // Input register: holds one request until its work is finished.
   logic                               in_valid_ff, in_valid_in;
   logic                               in_mode_ff;
   logic [mcr_pkg::CENTER_BITS-1:0]    in_cx_ff, in_cy_ff;
   logic [mcr_pkg::RADIUS_BITS-1:0]    in_radius_ff;
   logic                               in_fill_ff;

   // Result index within the current iteration.
   logic [IB-1:0]                      idx_ff, idx_in;

   // Result register.
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]                px_ff, py_a_ff, py_b_ff;
   logic                               last_ff, done_ff;

   mcr_pkg::mcr_ctl_type               ctl;
   logic [XB-1:0]                      cur_x, cur_y;
   logic [OUT_BITS-1:0]                origin_x, origin_y;
   logic                               fill_mode, run_ok, done_iter;
   logic [OUT_BITS-1:0]                pt_px, pt_py_a, pt_py_b;
   logic                               pt_last;

   logic                               is_start, is_adv, emitting;
   logic                               out_load, emit_fire, finish;

   mcr_core #(
      .COORD_BITS (COORD_BITS),
      .OUT_BITS   (OUT_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .load_cx     (in_cx_ff),
      .load_cy     (in_cy_ff),
      .load_radius (in_radius_ff),
      .load_fill   (in_fill_ff),
      .cur_x       (cur_x),
      .cur_y       (cur_y),
      .origin_x    (origin_x),
      .origin_y    (origin_y),
      .fill_mode   (fill_mode),
      .run_ok      (run_ok),
      .done_iter   (done_iter)
   );

   mcr_emit #(
      .OUT_BITS (OUT_BITS)
   ) u_emit (
      .cur_x     (cur_x),
      .cur_y     (cur_y),
      .origin_x  (origin_x),
      .origin_y  (origin_y),
      .fill_mode (fill_mode),
      .idx       (idx_ff),
      .px        (pt_px),
      .py_a      (pt_py_a),
      .py_b      (pt_py_b),
      .last      (pt_last)
   );

   // Sequencing. A start finishes at once; an advance while idle is dropped;
   // a live advance walks idx through its results, one per result-register load.
   always_comb begin
      is_start  = in_valid_ff && (in_mode_ff == mcr_pkg::MODE_START);
      is_adv    = in_valid_ff && (in_mode_ff == mcr_pkg::MODE_ADVANCE);
      emitting  = is_adv && run_ok;
      out_load  = !rsp_valid_ff || rsp_ready;
      emit_fire = emitting && out_load;
      finish    = is_start || (is_adv && !run_ok) || (emit_fire && pt_last);

      ctl.load  = is_start;
      ctl.step  = emit_fire && pt_last;

      // next request may enter in the same cycle the held one finishes
      req_ready   = !in_valid_ff || finish;
      in_valid_in = req_ready ? req_valid : in_valid_ff;

      idx_in = idx_ff;
      if (emit_fire) begin
         idx_in = pt_last ? '0 : idx_ff + IB'(1);
      end

      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_mode_ff   <= req_mode;
         in_cx_ff     <= req_center_x;
         in_cy_ff     <= req_center_y;
         in_radius_ff <= req_radius;
         in_fill_ff   <= req_fill;
      end
      if (emit_fire) begin
         px_ff   <= pt_px;
         py_a_ff <= pt_py_a;
         py_b_ff <= pt_py_b;
         last_ff <= pt_last;
         done_ff <= done_iter;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_px       = px_ff;
   assign rsp_py_a     = py_a_ff;
   assign rsp_py_b     = py_b_ff;
   assign rsp_last     = last_ff;
   assign rsp_done_res = done_ff;

endmodule
`default_nettype wire

@@ design/mcr_checker.sv @@
// Port-level checker for the midpoint circle rasterizer, bound to the top level.
// Depends on mcr_pkg and midpoint_circle_rasterizer_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "midpoint_circle_rasterizer_macros.svh"
module mcr_checker #(
   parameter int  COORD_BITS = mcr_pkg::COORD_BITS_DEF,
   localparam int OUT_BITS   = COORD_BITS + 1
) (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_valid,
   input wire                                req_ready,
   input wire                                req_mode,
   input wire  [mcr_pkg::CENTER_BITS-1:0]    req_center_x,
   input wire  [mcr_pkg::CENTER_BITS-1:0]    req_center_y,
   input wire  [mcr_pkg::RADIUS_BITS-1:0]    req_radius,
   input wire                                req_fill,
   input wire                                rsp_valid,
   input wire                                rsp_ready,
   input wire  [OUT_BITS-1:0]                rsp_px,
   input wire  [OUT_BITS-1:0]                rsp_py_a,
   input wire  [OUT_BITS-1:0]                rsp_py_b,
   input wire                                rsp_last,
   input wire                                rsp_done_res
);

   // stalled request holds
   `MCR_ASSERT(a_req_hold,
      req_valid && !req_ready |=> req_valid && $stable(req_mode) &&
      $stable(req_center_x) && $stable(req_center_y) && $stable(req_radius) &&
      $stable(req_fill),
      "req changed while stalled")

   // stalled result holds
   `MCR_ASSERT(a_rsp_hold,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_px) && $stable(rsp_py_a) &&
      $stable(rsp_py_b) && $stable(rsp_last) && $stable(rsp_done_res),
      "rsp changed while stalled")

   // results of one iteration follow back to back and agree on done
   `MCR_ASSERT(a_iter_cont,
      rsp_valid && rsp_ready && !rsp_last |=>
      rsp_valid && (rsp_done_res == $past(rsp_done_res)),
      "iteration results broken")

   `MCR_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid, "rsp valid after reset")

endmodule

bind midpoint_circle_rasterizer mcr_checker #(.COORD_BITS(COORD_BITS)) u_mcr_checker (.*);
`default_nettype wire

@@ verif/midpoint_circle_rasterizer_tb.sv @@
// Self-checking testbench for midpoint_circle_rasterizer: directed and random circles,
// with results checked in order against a cycle-free predictor of the midpoint loop.
// Depends on mcr_pkg and the midpoint_circle_rasterizer RTL.
`timescale 1ns / 1ps
module midpoint_circle_rasterizer_tb;

   localparam int COORD_BITS = mcr_pkg::COORD_BITS_DEF;
   localparam int OUT_BITS   = COORD_BITS + 1;
   localparam int CB         = mcr_pkg::CENTER_BITS;
   localparam int RB         = mcr_pkg::RADIUS_BITS;
   localparam int XB         = mcr_pkg::X_BITS;
   localparam int DB         = mcr_pkg::D_BITS;
   localparam int IDLE_PCT   = 23;        // percent of cycles a side idles
   localparam int SETTLE_CYC = 20;        // drain time after the last expected result

   // One request and one result, at port widths
   typedef struct {
      logic                 mode;
      logic signed [CB-1:0] cx;
      logic signed [CB-1:0] cy;
      logic [RB-1:0]        radius;
      logic                 fill;
   } req_item_type;

   typedef struct {
      logic signed [OUT_BITS-1:0] px;
      logic signed [OUT_BITS-1:0] py_a;
      logic signed [OUT_BITS-1:0] py_b;
      logic                       last;
      logic                       done_res;
   } rsp_item_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   wire                           req_ready;
   logic                          req_mode = mcr_pkg::MODE_START;
   logic signed [CB-1:0]          req_center_x = '0;
   logic signed [CB-1:0]          req_center_y = '0;
   logic [RB-1:0]                 req_radius = '0;
   logic                          req_fill = 1'b0;
   wire                           rsp_valid;
   logic                          rsp_ready = 1'b0;
   wire signed [OUT_BITS-1:0]     rsp_px;
   wire signed [OUT_BITS-1:0]     rsp_py_a;
   wire signed [OUT_BITS-1:0]     rsp_py_b;
   wire                           rsp_last;
   wire                           rsp_done_res;

   midpoint_circle_rasterizer #(.COORD_BITS(COORD_BITS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_center_x(req_center_x), .req_center_y(req_center_y),
      .req_radius(req_radius), .req_fill(req_fill),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_px(rsp_px),
      .rsp_py_a(rsp_py_a), .rsp_py_b(rsp_py_b), .rsp_last(rsp_last),
      .rsp_done_res(rsp_done_res)
   );

   always #4 clock = ~clock;

   req_item_type pending_reqs[$];     // stimulus not yet offered to the block
   rsp_item_type expected_pixels[$];  // predicted points/spans, oldest first

   // Predictor copy of the loop state
   logic signed [XB-1:0]          circ_x, circ_y;
   logic signed [DB-1:0]          circ_d;
   logic signed [CB-1:0]          circ_cx, circ_cy;
   logic                          circ_fill;
   logic                          circ_active;

   int error_count   = 0;
   int start_count   = 0;
   int advance_count = 0;
   int circle_count  = 0;
   int checked_count = 0;
   int accept_count  = 0;

   function automatic void queue_pixel(input logic signed [OUT_BITS-1:0] col,
                                       input logic signed [OUT_BITS-1:0] ra,
                                       input logic signed [OUT_BITS-1:0] rb,
                                       input logic lst, input logic dn);
      rsp_item_type r;
      r.px = col; r.py_a = ra; r.py_b = rb; r.last = lst; r.done_res = dn;
      expected_pixels.push_back(r);
   endfunction

   // One accepted request: update the predicted state and queue its results.
   function automatic void rasterize_step(input req_item_type it);
      logic signed [OUT_BITS-1:0] x, y, cx, cy;
      logic signed [XB-1:0]       nx, ny;
      logic signed [DB-1:0]       nd;
      logic                       dn;
      if (it.mode == mcr_pkg::MODE_START) begin
         circ_cx     = it.cx;
         circ_cy     = it.cy;
         circ_x      = $signed({1'b0, it.radius});
         circ_y      = '0;
         circ_d      = DB'(1 - circ_x);
         circ_fill   = it.fill;
         circ_active = 1'b1;
         return;
      end
      // advance while idle, or past the end of the loop: nothing happens
      if (!circ_active || circ_x < circ_y) return;
      x  = OUT_BITS'(circ_x);
      y  = OUT_BITS'(circ_y);
      cx = OUT_BITS'(circ_cx);
      cy = OUT_BITS'(circ_cy);
      ny = XB'(circ_y + 1);
      nx = circ_x;
      if (circ_d > 0) begin
         nx = XB'(circ_x - 1);
         nd = DB'(circ_d + 2 * (ny - nx) + 1);
      end else begin
         nd = DB'(circ_d + 2 * ny + 1);
      end
      dn = nx < ny;
      if (circ_fill) begin
         queue_pixel( x + cx,  y + cy, -y + cy, 1'b0, dn);
         queue_pixel( y + cx,  x + cy, -x + cy, 1'b0, dn);
         queue_pixel(-x + cx,  y + cy, -y + cy, 1'b0, dn);
         queue_pixel(-y + cx,  x + cy, -x + cy, 1'b1, dn);
      end else begin
         queue_pixel( x + cx,  y + cy,  y + cy, 1'b0, dn);
         queue_pixel( y + cx,  x + cy,  x + cy, 1'b0, dn);
         queue_pixel(-x + cx,  y + cy,  y + cy, 1'b0, dn);
         queue_pixel(-y + cx,  x + cy,  x + cy, 1'b0, dn);
         queue_pixel(-x + cx, -y + cy, -y + cy, 1'b0, dn);
         queue_pixel(-y + cx, -x + cy, -x + cy, 1'b0, dn);
         queue_pixel( x + cx, -y + cy, -y + cy, 1'b0, dn);
         queue_pixel( y + cx, -x + cy, -x + cy, 1'b1, dn);
      end
      circ_x = nx;
      circ_y = ny;
      circ_d = nd;
      if (dn) begin
         circ_active = 1'b0;
         circle_count++;
      end
   endfunction

   // Stimulus helpers: advance items carry random junk in the unused fields
   task automatic add_start(input logic signed [CB-1:0] cx,
                            input logic signed [CB-1:0] cy,
                            input logic [RB-1:0] r, input logic f);
      req_item_type it;
      it.mode = mcr_pkg::MODE_START; it.cx = cx; it.cy = cy; it.radius = r; it.fill = f;
      pending_reqs.push_back(it);
   endtask

   task automatic add_advances(input int n);
      req_item_type it;
      repeat (n) begin
         it.mode   = mcr_pkg::MODE_ADVANCE;
         it.cx     = CB'($urandom);
         it.cy     = CB'($urandom);
         it.radius = RB'($urandom);
         it.fill   = 1'($urandom);
         pending_reqs.push_back(it);
      end
   endtask

   function automatic logic signed [CB-1:0] pick_center();
      case ($urandom_range(5))
         0:       return 16'sh8000;                       // most negative
         1:       return 16'sh7fff;                       // most positive
         2:       return '0;
         default: return CB'($urandom);
      endcase
   endfunction

   // Driver: when the channel is free, offers the next pending request or idles at random.
   // The predictor runs on the transfer, in acceptance order.
   req_item_type on_bus;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            rasterize_step(on_bus);
            accept_count++;
            if (on_bus.mode == mcr_pkg::MODE_START) start_count++;
            else advance_count++;
         end
         if (!req_valid || req_ready) begin
            // the driver offers transfers 200..299 with no idling
            if (pending_reqs.size() != 0 &&
                ((accept_count >= 200 && accept_count < 300) ||
                 $urandom_range(99) >= IDLE_PCT)) begin
               on_bus = pending_reqs.pop_front();
               req_mode     <= on_bus.mode;
               req_center_x <= on_bus.cx;
               req_center_y <= on_bus.cy;
               req_radius   <= on_bus.radius;
               req_fill     <= on_bus.fill;
               req_valid    <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transfer against the oldest expectation
   // and throttles rsp_ready.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%t: result with nothing expected: px=%0d py_a=%0d py_b=%0d",
                           $realtime, rsp_px, rsp_py_a, rsp_py_b);
            end else begin
               want = expected_pixels.pop_front();
               checked_count++;
               if (rsp_px !== want.px || rsp_py_a !== want.py_a ||
                   rsp_py_b !== want.py_b || rsp_last !== want.last ||
                   rsp_done_res !== want.done_res) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("%t: result %0d mismatch: expected px=%0d py_a=%0d py_b=%0d",
                              $realtime, checked_count, want.px, want.py_a, want.py_b);
                     $display("   expected last=%0b done=%0b, got px=%0d py_a=%0d py_b=%0d",
                              want.last, want.done_res, rsp_px, rsp_py_a, rsp_py_b);
                     $display("   got last=%0b done=%0b", rsp_last, rsp_done_res);
                  end
               end
            end
         end
         // a stall-free window in the middle of the result stream
         rsp_ready <= (checked_count >= 600 && checked_count < 1100) ||
                      ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      int r;
      int n;
      // Directed part
      add_advances(1);                                   // advance while idle
      add_start(16'sd0, 16'sd0, 15'd0, 1'b0);            // zero radius, outline
      add_advances(2);                                   // completes, then idle again
      add_start(16'sh8000, 16'sh7fff, 15'd0, 1'b1);      // zero radius, fill
      add_advances(1);
      add_start(16'sh7fff, 16'sh8000, 15'h7fff, 1'b0);   // largest radius
      add_advances(2);
      add_start(16'sh8000, 16'sh7fff, 15'h7fff, 1'b1);   // restart while active
      add_advances(2);
      add_start(16'sh7fff, 16'sh7fff, 15'h7fff, 1'b0);
      add_advances(1);
      add_start(16'sh8000, 16'sh8000, 15'h7fff, 1'b1);
      add_advances(1);
      add_start(16'sd5, -16'sd7, 15'd1, 1'b0);           // radius one, run past the end
      add_advances(3);
      add_start(CB'($urandom), CB'($urandom), 15'd5, 1'b1);
      add_advances(5);

      // Random part: mostly complete circles of small radius
      while (pending_reqs.size() < 400) begin
         case ($urandom_range(9))
            0: begin                                     // noise: stray advances
               add_advances($urandom_range(1, 3));
            end
            1: begin                                     // huge radius, abandoned early
               add_start(pick_center(), pick_center(), RB'($urandom), 1'($urandom));
               add_advances($urandom_range(1, 6));
            end
            2: begin                                     // circle cut short by a restart
               add_start(pick_center(), pick_center(), RB'($urandom_range(4, 255)),
                         1'($urandom));
               add_advances($urandom_range(1, 4));
            end
            default: begin                               // full circle, a few spare advances
               r = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 24);
               n = (r * 3) / 4 + 1 + $urandom_range(0, 1);
               add_start(pick_center(), pick_center(), RB'(r), 1'($urandom));
               add_advances(n);
            end
         endcase
      end
   end

   // Reset, then wait for the stimulus and the results to drain
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      $display("Run covered %0d starts and %0d advances, %0d circles finished.",
               start_count, advance_count, circle_count);
      $display("%0d results checked, %0d errors.", checked_count, error_count);
      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4ms;
      $display("Timeout with %0d results still expected", expected_pixels.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
